@@ hw/rtl/rfdid_pkg.sv @@
// Package for the reader-frame to decimal card number block.
// Holds widths, character codes, item kinds, the converter state type and
// the structs that link the front part, the queue and the converter.
`default_nettype none

package rfdid_pkg;

	localparam int FRAME_BYTES = 12;
	localparam int HEX_FIRST   = 2;
	localparam int HEX_LAST    = 9;

	localparam int POS_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int TMO_W   = 8;
	localparam int NUM_W   = 32;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int CNT_W   = 4;
	localparam int RES_W   = NUM_W + BCD_W + CNT_W;
	localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
	localparam int PAD_W   = OUT_W - RES_W;
	localparam int WORK_W  = BCD_W + NUM_W;

	localparam int DABBLE_BITS   = 4;
	localparam int DABBLE_CYCLES = NUM_W / DABBLE_BITS;
	localparam int STEP_W        = $clog2(DABBLE_CYCLES);

	localparam int QUEUE_DEPTH = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [TMO_W-1:0] TIMEOUT_RESET = 8'd2;

	localparam logic [BYTE_W-1:0] ASCII_0      = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_9      = 8'h39;
	localparam logic [BYTE_W-1:0] ASCII_A      = 8'h41;
	localparam logic [BYTE_W-1:0] ASCII_F      = 8'h46;
	localparam logic [BYTE_W-1:0] ALPHA_OFFSET = 8'd55;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CONV,
		BK_HOLD
	} bk_state_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] number;
	} push_t;

	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] number;
	} head_t;

endpackage

`default_nettype wire

@@ hw/rtl/rfdid_front.sv @@
// Front part: takes bytes and ticks, assembles the frame and runs the
// inter-byte timeout. Pushes each finished card number into the queue.
// Depends on rfdid_pkg.
`default_nettype none

module rfdid_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire                          func,
	input  wire [rfdid_pkg::BYTE_W-1:0] byte_value,
	input  wire                          cfg_we,
	input  wire [rfdid_pkg::TMO_W-1:0]  cfg_value,
	output rfdid_pkg::push_t             push
);

	function automatic logic [3:0] nibble_of(input logic [rfdid_pkg::BYTE_W-1:0] c);
		logic [rfdid_pkg::BYTE_W-1:0] d;
		begin
			d = '0;
			if (c >= rfdid_pkg::ASCII_0 && c <= rfdid_pkg::ASCII_9) begin
				d = c - rfdid_pkg::ASCII_0;
			end else if (c >= rfdid_pkg::ASCII_A && c <= rfdid_pkg::ASCII_F) begin
				d = c - rfdid_pkg::ALPHA_OFFSET;
			end
			nibble_of = d[3:0];
		end
	endfunction

	logic [rfdid_pkg::POS_W-1:0] pos_q;
	logic [rfdid_pkg::NUM_W-1:0] acc_q;
	logic [rfdid_pkg::TMO_W-1:0] tmo_q;
	logic [rfdid_pkg::TMO_W-1:0] cfg_q;

	logic                        is_byte;
	logic                        is_tick;
	logic                        in_hex;
	logic                        frame_done;
	logic                        expire;
	logic [rfdid_pkg::POS_W-1:0] pos_inc;
	logic [rfdid_pkg::NUM_W-1:0] acc_next;

	assign is_byte  = accept && (func == rfdid_pkg::FUNC_BYTE);
	assign is_tick  = accept && (func == rfdid_pkg::FUNC_TICK);
	assign in_hex   = (pos_q >= rfdid_pkg::POS_W'(rfdid_pkg::HEX_FIRST)) &&
		(pos_q <= rfdid_pkg::POS_W'(rfdid_pkg::HEX_LAST));
	assign acc_next = in_hex ? {acc_q[rfdid_pkg::NUM_W-5:0], nibble_of(byte_value)} : acc_q;
	assign pos_inc  = pos_q + 1'b1;
	assign frame_done = pos_inc == rfdid_pkg::POS_W'(rfdid_pkg::FRAME_BYTES);
	assign expire   = is_tick && (tmo_q == rfdid_pkg::TMO_W'(1));

	assign push.valid  = is_byte && frame_done;
	assign push.number = acc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rfdid_pkg::TIMEOUT_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			acc_q <= '0;
			tmo_q <= '0;
		end else if (is_byte) begin
			tmo_q <= cfg_q;
			if (frame_done) begin
				pos_q <= '0;
				acc_q <= '0;
			end else begin
				pos_q <= pos_inc;
				acc_q <= acc_next;
			end
		end else if (is_tick && tmo_q != '0) begin
			tmo_q <= tmo_q - 1'b1;
			if (expire) begin
				pos_q <= '0;
				acc_q <= '0;
			end
		end
	end

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < rfdid_pkg::POS_W'(rfdid_pkg::FRAME_BYTES))
		else $error("Frame position ran past the frame length.");

endmodule

`default_nettype wire

@@ hw/rtl/rfdid_queue.sv @@
// Short queue of finished card numbers between the front part and the
// converter. Depends on rfdid_pkg.
`default_nettype none

module rfdid_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire rfdid_pkg::push_t push,
	input  wire                   pop,
	output rfdid_pkg::head_t      head,
	output logic                  full
);

	logic [rfdid_pkg::NUM_W-1:0]  mem_q [rfdid_pkg::QUEUE_DEPTH];
	logic [rfdid_pkg::PTR_W-1:0]  wr_q;
	logic [rfdid_pkg::PTR_W-1:0]  rd_q;
	logic [rfdid_pkg::QCNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full        = cnt_q == rfdid_pkg::QCNT_W'(rfdid_pkg::QUEUE_DEPTH);
	assign head.valid  = cnt_q != '0;
	assign head.number = mem_q[rd_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("Word pushed into a full queue.");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("Word popped from an empty queue.");

endmodule

`default_nettype wire

@@ hw/rtl/rfdid_back.sv @@
// Converter: takes card numbers from the queue, turns them into ten BCD
// digits with a shift-and-add-3 loop, four bits per cycle, and counts the
// significant digits. Holds the result in the output register. Depends on rfdid_pkg.
`default_nettype none

module rfdid_back (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire rfdid_pkg::head_t         head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [rfdid_pkg::OUT_W-1:0]   m_tdata
);

	function automatic logic [rfdid_pkg::WORK_W-1:0] dabble_bit(
			input logic [rfdid_pkg::WORK_W-1:0] v);
		logic [rfdid_pkg::WORK_W-1:0] t;
		begin
			t = v;
			for (int d = 0; d < rfdid_pkg::DIGITS; d++) begin
				if (t[rfdid_pkg::NUM_W + 4*d +: 4] >= 4'd5) begin
					t[rfdid_pkg::NUM_W + 4*d +: 4] = t[rfdid_pkg::NUM_W + 4*d +: 4] + 4'd3;
				end
			end
			dabble_bit = {t[rfdid_pkg::WORK_W-2:0], 1'b0};
		end
	endfunction

	rfdid_pkg::bk_state_t state_q;
	rfdid_pkg::bk_state_t state_d;

	logic [rfdid_pkg::WORK_W-1:0]   work_q;
	logic [rfdid_pkg::WORK_W-1:0]   work_next;
	logic [rfdid_pkg::NUM_W-1:0]    num_q;
	logic [rfdid_pkg::STEP_W-1:0]   step_q;
	logic                           last_step;
	logic                           load_out;
	logic                           out_free;
	logic [rfdid_pkg::CNT_W-1:0]    count;

	logic                           out_valid_q;
	logic [rfdid_pkg::NUM_W-1:0]    out_num_q;
	logic [rfdid_pkg::BCD_W-1:0]    out_bcd_q;
	logic [rfdid_pkg::CNT_W-1:0]    out_cnt_q;

	assign last_step = step_q == rfdid_pkg::STEP_W'(rfdid_pkg::DABBLE_CYCLES - 1);
	assign out_free  = !out_valid_q || m_tready;

	always_comb begin
		work_next = work_q;
		for (int s = 0; s < rfdid_pkg::DABBLE_BITS; s++) begin
			work_next = dabble_bit(work_next);
		end
	end

	always_comb begin
		count = '0;
		for (int d = 0; d < rfdid_pkg::DIGITS; d++) begin
			if (work_q[rfdid_pkg::NUM_W + 4*d +: 4] != 4'd0) begin
				count = rfdid_pkg::CNT_W'(d + 1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rfdid_pkg::BK_IDLE: begin
				if (head.valid) begin
					state_d = rfdid_pkg::BK_CONV;
				end
			end
			rfdid_pkg::BK_CONV: begin
				if (last_step) begin
					state_d = rfdid_pkg::BK_HOLD;
				end
			end
			rfdid_pkg::BK_HOLD: begin
				if (out_free) begin
					state_d = rfdid_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = rfdid_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			rfdid_pkg::BK_IDLE: pop      = head.valid;
			rfdid_pkg::BK_HOLD: load_out = out_free;
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfdid_pkg::BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				step_q <= '0;
			end else if (state_q == rfdid_pkg::BK_CONV) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= {{rfdid_pkg::BCD_W{1'b0}}, head.number};
			num_q  <= head.number;
		end else if (state_q == rfdid_pkg::BK_CONV) begin
			work_q <= work_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_num_q <= num_q;
			out_bcd_q <= work_q[rfdid_pkg::WORK_W-1:rfdid_pkg::NUM_W];
			out_cnt_q <= count;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{rfdid_pkg::PAD_W{1'b0}}, out_cnt_q, out_bcd_q, out_num_q};

	a_step_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rfdid_pkg::BK_CONV && !last_step) |=>
		(state_q == rfdid_pkg::BK_CONV && step_q == $past(step_q) + 1'b1))
		else $error("Converter step count did not advance.");

	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_cnt_q == '0) == (out_num_q == '0)))
		else $error("Digit count disagrees with a zero card number.");

endmodule

`default_nettype wire

@@ hw/rtl/rfid_frame_to_decimal_id.sv @@
// The last frame byte pushes its card number into a two-entry queue; the converter pops it, runs
// its shift-and-add-3 steps of four bits each and loads the output register once that is free.
// Throughput: one input word per cycle; the converter takes a new card number only after the last is loaded out.
// Input is refused only while that queue is full.
// Reset: arst_n clears the frame, stops the timer, sets the timeout register to 2 and empties
// the queue and the output register; there is no clearing pass.
`default_nettype none

module rfid_frame_to_decimal_id (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [rfdid_pkg::BYTE_W-1:0] s_tdata,   // [7:0] byte_value
	input  wire                          s_tuser,   // [0] func: 0 byte, 1 tick
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [rfdid_pkg::OUT_W-1:0]  m_tdata,   // [31:0] card_number, [71:32] decimal_digits, [75:72] digit_count, [79:76] zero
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [rfdid_pkg::TMO_W-1:0]  cfg_data   // [7:0] inter_byte_timeout
);

	rfdid_pkg::push_t push;
	rfdid_pkg::head_t head;
	logic             full;
	logic             pop;

	assign s_tready  = !full;
	assign cfg_ready = 1'b1;

	rfdid_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_tvalid && s_tready),
		.func       (s_tuser),
		.byte_value (s_tdata),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_value  (cfg_data),
		.push       (push)
	);

	rfdid_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full)
	);

	rfdid_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
